@@ rtl/chip8_instruction_core_unit_defines.svh @@
// Assertion macros shared by the core RTL.
`ifndef CHIP8_INSTRUCTION_CORE_UNIT_DEFINES_SVH
`define CHIP8_INSTRUCTION_CORE_UNIT_DEFINES_SVH

`ifndef SYNTH
`define CIU_ASSERT_IMM(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define CIU_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define CIU_ASSERT_IMM(label, clk, rst, ante, cons, msg)
`define CIU_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif

`endif

@@ rtl/ciu_pkg.sv @@
package ciu_pkg;

   localparam int MEM_BYTES        = 4096;
   localparam int MEM_AW           = 12;
   localparam int DEF_SCREEN_WIDTH  = 64;
   localparam int DEF_SCREEN_HEIGHT = 32;
   localparam int DEF_STACK_DEPTH   = 16;
   localparam int REG_COUNT        = 16;

   localparam logic [11:0] START_RESET = 12'h200;

   localparam logic [2:0] OP_LOAD     = 3'd0;
   localparam logic [2:0] OP_STEP     = 3'd1;
   localparam logic [2:0] OP_RD_BYTE  = 3'd2;
   localparam logic [2:0] OP_RD_PIXEL = 3'd3;
   localparam logic [2:0] OP_RD_REG   = 3'd4;

   localparam logic [3:0] GRP_SYS   = 4'h0;
   localparam logic [3:0] GRP_JUMP  = 4'h1;
   localparam logic [3:0] GRP_CALL  = 4'h2;
   localparam logic [3:0] GRP_SEQI  = 4'h3;
   localparam logic [3:0] GRP_SNEI  = 4'h4;
   localparam logic [3:0] GRP_SEQR  = 4'h5;
   localparam logic [3:0] GRP_LDI   = 4'h6;
   localparam logic [3:0] GRP_ADDI  = 4'h7;
   localparam logic [3:0] GRP_ALU   = 4'h8;
   localparam logic [3:0] GRP_SNER  = 4'h9;
   localparam logic [3:0] GRP_LDIDX = 4'hA;
   localparam logic [3:0] GRP_JMPV0 = 4'hB;
   localparam logic [3:0] GRP_DRAW  = 4'hD;

   localparam logic [15:0] INS_CLS = 16'h00E0;
   localparam logic [15:0] INS_RET = 16'h00EE;

   localparam logic [3:0] ALU_MOV = 4'h0;
   localparam logic [3:0] ALU_OR  = 4'h1;
   localparam logic [3:0] ALU_AND = 4'h2;
   localparam logic [3:0] ALU_XOR = 4'h3;
   localparam logic [3:0] ALU_ADD = 4'h4;
   localparam logic [3:0] ALU_SUB = 4'h5;
   localparam logic [3:0] ALU_SHR = 4'h6;
   localparam logic [3:0] ALU_SBN = 4'h7;
   localparam logic [3:0] ALU_SHL = 4'hE;

   localparam logic [3:0] REG_FLAG = 4'hF;

   typedef enum logic [4:0] {
      S_CLEAR,
      S_IDLE,
      S_MEMRD,
      S_FBRD,
      S_REGRD,
      S_FHI,
      S_FLO,
      S_RX,
      S_RY,
      S_R0,
      S_EXEC,
      S_FLAG,
      S_CLS,
      S_DRMEM,
      S_DRBYTE,
      S_DRBIT,
      S_DRPIX,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [2:0]  op;
      logic [11:0] address;
      logic [7:0]  write_byte;
   } req_word_type;

   typedef struct packed {
      logic [7:0]  read_value;
      logic [11:0] program_counter;
      logic [11:0] index_value;
      logic        collision;
      logic        stack_fault;
   } rsp_word_type;

   typedef logic [11:0] csr_word_type;

endpackage

@@ rtl/ciu_chan_if.sv @@
interface ciu_chan_if #(parameter type word_type = logic);
   logic     valid;
   logic     ready;
   word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/chip8_instruction_core_unit.sv @@
// channel   role   word                         handshake
// req_chan  sink   op, address, write_byte      valid/ready
// rsp_chan  source read_value, pc, index, flags valid/ready
// csr_chan  sink   start_address                valid/ready, ready while idle
//
// After reset a clearing pass zeroes byte memory and framebuffer; no word is taken
// meanwhile. A load goes from S_IDLE to S_DONE; a read passes S_MEMRD, S_FBRD or
// S_REGRD; a step passes S_FHI, S_FLO, S_RX, S_RY, S_R0, S_EXEC and, for VF-writing
// ops, S_FLAG. Draw passes S_DRMEM and S_DRBYTE per sprite row, S_DRBIT per sprite
// bit and S_DRPIX per set bit; clear screen writes every pixel in S_CLS.
// A finished word waits in the output register; the next word is taken meanwhile.
`include "chip8_instruction_core_unit_defines.svh"

module chip8_instruction_core_unit
   import ciu_pkg::*;
#(
   parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT,
   parameter int STACK_DEPTH   = DEF_STACK_DEPTH
) (
   input logic       clock,
   input logic       reset,
   ciu_chan_if.sink   req_chan,
   ciu_chan_if.source rsp_chan,
   ciu_chan_if.sink   csr_chan
);

   localparam int PIX     = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int PIXW    = $clog2(PIX);
   localparam int PXW     = $clog2(SCREEN_WIDTH);
   localparam int PYW     = $clog2(SCREEN_HEIGHT);
   localparam int CLR_MAX = (MEM_BYTES > PIX) ? MEM_BYTES : PIX;
   localparam int CLRW    = $clog2(CLR_MAX);
   localparam int SDW     = $clog2(STACK_DEPTH + 1);
   localparam int SIW     = $clog2(STACK_DEPTH);

   function automatic logic [7:0] wrap_mod(logic [7:0] v, logic [7:0] m);
      logic [7:0] r;
      r = v;
      for (int i = 0; i < 8; i++) begin
         if (r >= m) begin
            r = r - m;
         end
      end
      return r;
   endfunction

   state_type state_ff, state_in;

   logic [7:0]  main_mem [MEM_BYTES];
   logic        fb_mem [PIX];
   logic [7:0]  reg_mem [REG_COUNT];
   logic [REG_COUNT-1:0] reg_valid_ff;
   logic [11:0] stack_ff [STACK_DEPTH];

   logic [7:0]  mem_q_ff;
   logic        fb_q_ff;
   logic [7:0]  reg_q_ff;

   logic [11:0] mem_raddr, mem_waddr;
   logic        mem_we;
   logic [7:0]  mem_wdata;
   logic [PIXW-1:0] fb_raddr, fb_waddr;
   logic        fb_we, fb_wdata;
   logic [3:0]  reg_raddr, reg_waddr;
   logic        reg_we;
   logic [7:0]  reg_wdata;

   logic [15:0] ir_ff;
   logic [7:0]  vx_ff, vy_ff, v0_ff, rd_ff, sprite_ff;
   logic        flag_ff, hit_ff, fault_ff, rd_ok_ff;
   logic [11:0] pc_ff, idx_ff;
   logic [SDW-1:0] depth_ff;
   logic [PXW-1:0] px_ff, pxc_ff;
   logic [PYW-1:0] py_ff;
   logic [3:0]  row_ff;
   logic [2:0]  col_ff;
   logic [CLRW-1:0] clr_ff;
   logic        rsp_valid_ff;
   rsp_word_type rsp_word_ff;

   logic [3:0]  grp, xi, yi, nib;
   logic [7:0]  nn;
   logic [11:0] nnn;
   logic        req_take, rsp_free, last_col, last_row, bit_set;
   logic [PXW-1:0] pxc_inc;
   logic [PYW-1:0] py_inc;
   logic [PIXW-1:0] pix_idx;
   logic [11:0] pc_exec;
   logic        push, pop, fault_exec, flag_exec;
   logic [7:0]  alu_val;
   logic [8:0]  sum9;
   logic [SDW-1:0] depth_dec;

   assign grp = ir_ff[15:12];
   assign xi  = ir_ff[11:8];
   assign yi  = ir_ff[7:4];
   assign nib = ir_ff[3:0];
   assign nn  = ir_ff[7:0];
   assign nnn = ir_ff[11:0];

   assign req_chan.ready = (state_ff == S_IDLE);
   assign csr_chan.ready = (state_ff == S_IDLE);
   assign req_take  = req_chan.valid && (state_ff == S_IDLE);
   assign rsp_free  = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_word_ff;

   assign last_col = (col_ff == 3'd7);
   assign last_row = ((row_ff + 4'd1) == nib);
   assign bit_set  = sprite_ff[3'd7 - col_ff];
   assign pxc_inc  = (pxc_ff == PXW'(SCREEN_WIDTH - 1)) ? '0 : pxc_ff + PXW'(1);
   assign py_inc   = (py_ff == PYW'(SCREEN_HEIGHT - 1)) ? '0 : py_ff + PYW'(1);
   assign pix_idx  = PIXW'(PIXW'(py_ff) * PIXW'(SCREEN_WIDTH)) + PIXW'(pxc_ff);
   assign depth_dec = depth_ff - SDW'(1);
   assign sum9     = {1'b0, vx_ff} + {1'b0, vy_ff};

   always_comb begin
      pc_exec    = pc_ff;
      push       = 1'b0;
      pop        = 1'b0;
      fault_exec = 1'b0;
      flag_exec  = 1'b0;
      alu_val    = vx_ff;
      case (grp)
         GRP_SYS: begin
            if (ir_ff == INS_RET) begin
               if (depth_ff == '0) begin
                  fault_exec = 1'b1;
               end else begin
                  pop     = 1'b1;
                  pc_exec = stack_ff[depth_dec[SIW-1:0]];
               end
            end
         end
         GRP_JUMP: pc_exec = nnn - 12'd2;
         GRP_CALL: begin
            if (depth_ff >= SDW'(STACK_DEPTH)) begin
               fault_exec = 1'b1;
            end else begin
               push    = 1'b1;
               pc_exec = nnn - 12'd2;
            end
         end
         GRP_SEQI: if (vx_ff == nn) pc_exec = pc_ff + 12'd2;
         GRP_SNEI: if (vx_ff != nn) pc_exec = pc_ff + 12'd2;
         GRP_SEQR: if (vx_ff == vy_ff) pc_exec = pc_ff + 12'd2;
         GRP_SNER: if (vx_ff != vy_ff) pc_exec = pc_ff + 12'd2;
         GRP_LDI:  alu_val = nn;
         GRP_ADDI: alu_val = vx_ff + nn;
         GRP_JMPV0: pc_exec = nnn + {4'd0, v0_ff} - 12'd2;
         GRP_ALU: begin
            case (nib)
               ALU_MOV: alu_val = vy_ff;
               ALU_OR:  alu_val = vx_ff | vy_ff;
               ALU_AND: alu_val = vx_ff & vy_ff;
               ALU_XOR: alu_val = vx_ff ^ vy_ff;
               ALU_ADD: begin
                  alu_val   = sum9[7:0];
                  flag_exec = sum9[8];
               end
               ALU_SUB: begin
                  alu_val   = vx_ff - vy_ff;
                  flag_exec = (vx_ff >= vy_ff);
               end
               ALU_SBN: begin
                  alu_val   = vy_ff - vx_ff;
                  flag_exec = (vy_ff >= vx_ff);
               end
               ALU_SHR: begin
                  alu_val   = {1'b0, vy_ff[7:1]};
                  flag_exec = vy_ff[0];
               end
               ALU_SHL: begin
                  alu_val   = {vy_ff[6:0], 1'b0};
                  flag_exec = vy_ff[7];
               end
               default: alu_val = vx_ff;
            endcase
         end
         default: pc_exec = pc_ff;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: if (clr_ff == CLRW'(CLR_MAX - 1)) state_in = S_IDLE;
         S_IDLE: begin
            if (req_chan.valid) begin
               case (req_chan.data.op)
                  OP_STEP:     state_in = S_FHI;
                  OP_RD_BYTE:  state_in = S_MEMRD;
                  OP_RD_PIXEL: state_in = S_FBRD;
                  OP_RD_REG:   state_in = S_REGRD;
                  default:     state_in = S_DONE;
               endcase
            end
         end
         S_MEMRD, S_FBRD, S_REGRD: state_in = S_DONE;
         S_FHI: state_in = S_FLO;
         S_FLO: state_in = S_RX;
         S_RX:  state_in = S_RY;
         S_RY:  state_in = S_R0;
         S_R0:  state_in = S_EXEC;
         S_EXEC: begin
            if (ir_ff == INS_CLS) begin
               state_in = S_CLS;
            end else if (grp == GRP_DRAW) begin
               state_in = (nib == 4'd0) ? S_FLAG : S_DRMEM;
            end else if (grp == GRP_ALU && (nib == ALU_ADD || nib == ALU_SUB ||
                         nib == ALU_SBN || nib == ALU_SHR || nib == ALU_SHL)) begin
               state_in = S_FLAG;
            end else begin
               state_in = S_DONE;
            end
         end
         S_FLAG: state_in = S_DONE;
         S_CLS:  if (clr_ff == CLRW'(PIX - 1)) state_in = S_DONE;
         S_DRMEM:  state_in = S_DRBYTE;
         S_DRBYTE: state_in = S_DRBIT;
         S_DRBIT, S_DRPIX: begin
            if (state_ff == S_DRBIT && bit_set) begin
               state_in = S_DRPIX;
            end else if (last_col) begin
               state_in = last_row ? S_FLAG : S_DRMEM;
            end else begin
               state_in = S_DRBIT;
            end
         end
         S_DONE: if (rsp_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      mem_raddr = pc_ff;
      mem_we    = 1'b0;
      mem_waddr = req_chan.data.address;
      mem_wdata = req_chan.data.write_byte;
      fb_raddr  = pix_idx;
      fb_we     = 1'b0;
      fb_waddr  = pix_idx;
      fb_wdata  = !fb_q_ff;
      reg_raddr = xi;
      reg_we    = 1'b0;
      reg_waddr = xi;
      reg_wdata = alu_val;
      case (state_ff)
         S_CLEAR: begin
            mem_we    = (32'(clr_ff) < MEM_BYTES);
            mem_waddr = clr_ff[MEM_AW-1:0];
            mem_wdata = '0;
            fb_we     = (32'(clr_ff) < PIX);
            fb_waddr  = clr_ff[PIXW-1:0];
            fb_wdata  = 1'b0;
         end
         S_IDLE: begin
            mem_we    = req_take && (req_chan.data.op == OP_LOAD);
            mem_raddr = (req_chan.data.op == OP_STEP) ? pc_ff : req_chan.data.address;
            fb_raddr  = PIXW'(req_chan.data.address);
            reg_raddr = req_chan.data.address[3:0];
         end
         S_FHI: mem_raddr = pc_ff + 12'd1;
         S_RX:  reg_raddr = yi;
         S_RY:  reg_raddr = 4'd0;
         S_EXEC: begin
            reg_we = (grp == GRP_LDI) || (grp == GRP_ADDI) ||
                     (grp == GRP_ALU && (nib == ALU_MOV || nib == ALU_OR ||
                      nib == ALU_AND || nib == ALU_XOR || nib == ALU_ADD ||
                      nib == ALU_SUB || nib == ALU_SBN || nib == ALU_SHR ||
                      nib == ALU_SHL));
         end
         S_FLAG: begin
            reg_we    = 1'b1;
            reg_waddr = REG_FLAG;
            reg_wdata = {7'd0, flag_ff};
         end
         S_CLS: begin
            fb_we    = 1'b1;
            fb_waddr = clr_ff[PIXW-1:0];
            fb_wdata = 1'b0;
         end
         S_DRMEM: mem_raddr = idx_ff + {8'd0, row_ff};
         S_DRPIX: fb_we = 1'b1;
         default: mem_raddr = pc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         main_mem[mem_waddr] <= mem_wdata;
      end
      mem_q_ff <= main_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (fb_we) begin
         fb_mem[fb_waddr] <= fb_wdata;
      end
      fb_q_ff <= fb_mem[fb_raddr];
   end

   always_ff @(posedge clock) begin
      if (reg_we) begin
         reg_mem[reg_waddr] <= reg_wdata;
      end
      reg_q_ff <= reg_valid_ff[reg_raddr] ? reg_mem[reg_raddr] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reg_valid_ff <= '0;
      end else if (reg_we) begin
         reg_valid_ff[reg_waddr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_EXEC && push) begin
         stack_ff[depth_ff[SIW-1:0]] <= pc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         pc_ff        <= START_RESET;
         idx_ff       <= '0;
         depth_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_chan.valid && csr_chan.ready) begin
            pc_ff <= csr_chan.data;
         end
         if (state_ff == S_DONE && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_CLEAR: clr_ff <= clr_ff + CLRW'(1);
            S_EXEC: begin
               clr_ff <= '0;
               pc_ff  <= pc_exec + 12'd2;
               if (grp == GRP_LDIDX) begin
                  idx_ff <= nnn;
               end
               if (push) begin
                  depth_ff <= depth_ff + SDW'(1);
               end
               if (pop) begin
                  depth_ff <= depth_dec;
               end
            end
            S_CLS: clr_ff <= clr_ff + CLRW'(1);
            default: clr_ff <= clr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            rd_ff    <= '0;
            hit_ff   <= 1'b0;
            fault_ff <= 1'b0;
            rd_ok_ff <= (req_chan.data.op == OP_RD_PIXEL) ?
                        (32'(req_chan.data.address) < 32'(PIX)) :
                        (req_chan.data.address < 12'd16);
         end
         S_MEMRD: rd_ff <= mem_q_ff;
         S_FBRD:  rd_ff <= rd_ok_ff ? {7'd0, fb_q_ff} : '0;
         S_REGRD: rd_ff <= rd_ok_ff ? reg_q_ff : '0;
         S_FHI:   ir_ff[15:8] <= mem_q_ff;
         S_FLO:   ir_ff[7:0]  <= mem_q_ff;
         S_RX:    vx_ff <= reg_q_ff;
         S_RY:    vy_ff <= reg_q_ff;
         S_R0:    v0_ff <= reg_q_ff;
         S_EXEC: begin
            fault_ff <= fault_exec;
            flag_ff  <= (grp == GRP_DRAW) ? 1'b0 : flag_exec;
            px_ff    <= PXW'(wrap_mod(vx_ff, 8'(SCREEN_WIDTH)));
            py_ff    <= PYW'(wrap_mod(vy_ff, 8'(SCREEN_HEIGHT)));
            row_ff   <= '0;
         end
         S_DRBYTE: begin
            sprite_ff <= mem_q_ff;
            col_ff    <= '0;
            pxc_ff    <= px_ff;
         end
         S_DRBIT, S_DRPIX: begin
            if (state_ff == S_DRPIX) begin
               hit_ff  <= hit_ff | fb_q_ff;
               flag_ff <= hit_ff | fb_q_ff;
            end
            if (!(state_ff == S_DRBIT && bit_set)) begin
               col_ff <= col_ff + 3'd1;
               pxc_ff <= pxc_inc;
               if (last_col) begin
                  row_ff <= row_ff + 4'd1;
                  py_ff  <= py_inc;
               end
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_word_ff.read_value      <= rd_ff;
               rsp_word_ff.program_counter <= pc_ff;
               rsp_word_ff.index_value     <= idx_ff;
               rsp_word_ff.collision       <= hit_ff;
               rsp_word_ff.stack_fault     <= fault_ff;
            end
         end
         default: rd_ff <= rd_ff;
      endcase
   end

   `CIU_ASSERT_IMM(a_depth_bound, clock, reset, 1'b1, depth_ff <= SDW'(STACK_DEPTH), "stack depth beyond limit")
   `CIU_ASSERT_NXT(a_accept_busy, clock, reset, req_chan.valid && req_chan.ready, state_ff != S_IDLE, "accepted word left core idle")
   `CIU_ASSERT_NXT(a_rsp_from_done, clock, reset, !rsp_chan.valid && state_ff != S_DONE, !rsp_chan.valid, "result word without completion")
   `CIU_ASSERT_IMM(a_row_bound, clock, reset, state_ff == S_DRMEM, row_ff < nib, "sprite row beyond height")

endmodule

@@ tb/tb.sv @@
module tb;
   import ciu_pkg::*;

   class core_scoreboard;
      logic [7:0]   mem [MEM_BYTES];
      bit           pix [DEF_SCREEN_WIDTH * DEF_SCREEN_HEIGHT];
      logic [7:0]   v [REG_COUNT];
      logic [11:0]  stk [DEF_STACK_DEPTH];
      logic [11:0]  pc;
      logic [11:0]  idx;
      int           depth;
      int           errors;
      rsp_word_type due [$];

      function new();
         foreach (mem[i]) mem[i] = '0;
         foreach (pix[i]) pix[i] = 0;
         foreach (v[i]) v[i] = '0;
         foreach (stk[i]) stk[i] = '0;
         pc = START_RESET;
         idx = '0;
         depth = 0;
         errors = 0;
      endfunction

      task report(string s);
         $display("mismatch: %s", s);
         errors++;
      endtask

      function void set_start(logic [11:0] a);
         pc = a;
      endfunction

      function void execute(inout rsp_word_type e);
         logic [15:0] code;
         logic [11:0] npc;
         logic [11:0] nnn;
         logic [3:0]  x;
         logic [3:0]  y;
         logic [3:0]  n;
         logic [7:0]  nn;
         logic [7:0]  a;
         logic [7:0]  b;
         logic [7:0]  bits;
         logic [8:0]  sum;
         int          py;
         int          px;
         bit          hit;
         code = {mem[pc], mem[pc + 12'd1]};
         x = code[11:8];
         y = code[7:4];
         n = code[3:0];
         nn = code[7:0];
         nnn = code[11:0];
         npc = pc;
         a = v[x];
         b = v[y];
         case (code[15:12])
            GRP_SYS: begin
               if (code == INS_CLS) begin
                  foreach (pix[i]) pix[i] = 0;
               end else if (code == INS_RET) begin
                  if (depth == 0) begin
                     e.stack_fault = 1'b1;
                  end else begin
                     depth--;
                     npc = stk[depth];
                  end
               end
            end
            GRP_JUMP: npc = nnn - 12'd2;
            GRP_CALL: begin
               if (depth >= DEF_STACK_DEPTH) begin
                  e.stack_fault = 1'b1;
               end else begin
                  stk[depth] = pc;
                  depth++;
                  npc = nnn - 12'd2;
               end
            end
            GRP_SEQI: if (a == nn) npc = pc + 12'd2;
            GRP_SNEI: if (a != nn) npc = pc + 12'd2;
            GRP_SEQR: if (a == b) npc = pc + 12'd2;
            GRP_SNER: if (a != b) npc = pc + 12'd2;
            GRP_LDI: v[x] = nn;
            GRP_ADDI: v[x] = a + nn;
            GRP_ALU: begin
               case (n)
                  ALU_MOV: v[x] = b;
                  ALU_OR:  v[x] = a | b;
                  ALU_AND: v[x] = a & b;
                  ALU_XOR: v[x] = a ^ b;
                  ALU_ADD: begin
                     sum = {1'b0, a} + {1'b0, b};
                     v[x] = sum[7:0];
                     v[REG_FLAG] = {7'd0, sum[8]};
                  end
                  ALU_SUB: begin
                     v[x] = a - b;
                     v[REG_FLAG] = {7'd0, a >= b};
                  end
                  ALU_SBN: begin
                     v[x] = b - a;
                     v[REG_FLAG] = {7'd0, b >= a};
                  end
                  ALU_SHR: begin
                     v[x] = b >> 1;
                     v[REG_FLAG] = {7'd0, b[0]};
                  end
                  ALU_SHL: begin
                     v[x] = b << 1;
                     v[REG_FLAG] = {7'd0, b[7]};
                  end
                  default: ;
               endcase
            end
            GRP_LDIDX: idx = nnn;
            GRP_JMPV0: npc = nnn + {4'd0, v[0]} - 12'd2;
            GRP_DRAW: begin
               hit = 0;
               v[REG_FLAG] = '0;
               for (int r = 0; r < n; r++) begin
                  bits = mem[idx + 12'(r)];
                  py = (b + r) % DEF_SCREEN_HEIGHT;
                  for (int c = 0; c < 8; c++) begin
                     if (bits[7 - c]) begin
                        px = (a + c) % DEF_SCREEN_WIDTH;
                        if (pix[py * DEF_SCREEN_WIDTH + px]) hit = 1;
                        pix[py * DEF_SCREEN_WIDTH + px] ^= 1'b1;
                     end
                  end
               end
               if (hit) begin
                  v[REG_FLAG] = 8'd1;
                  e.collision = 1'b1;
               end
            end
            default: ;
         endcase
         pc = npc + 12'd2;
      endfunction

      function void note(req_word_type w);
         rsp_word_type e;
         e = '0;
         case (w.op)
            OP_LOAD: mem[w.address] = w.write_byte;
            OP_STEP: execute(e);
            OP_RD_BYTE: e.read_value = mem[w.address];
            OP_RD_PIXEL: begin
               if (w.address < DEF_SCREEN_WIDTH * DEF_SCREEN_HEIGHT)
                  e.read_value = {7'd0, pix[w.address]};
            end
            OP_RD_REG: if (w.address < REG_COUNT) e.read_value = v[w.address[3:0]];
            default: ;
         endcase
         e.program_counter = pc;
         e.index_value = idx;
         due.push_back(e);
      endfunction

      task check(rsp_word_type g);
         rsp_word_type e;
         if (due.size() == 0) begin
            report("result with nothing pending");
         end else begin
            e = due.pop_front();
            if (g.read_value !== e.read_value)
               report($sformatf("read_value %0h want %0h", g.read_value, e.read_value));
            if (g.program_counter !== e.program_counter)
               report($sformatf("program_counter %0h want %0h",
                                g.program_counter, e.program_counter));
            if (g.index_value !== e.index_value)
               report($sformatf("index_value %0h want %0h", g.index_value, e.index_value));
            if (g.collision !== e.collision)
               report($sformatf("collision %0b want %0b", g.collision, e.collision));
            if (g.stack_fault !== e.stack_fault)
               report($sformatf("stack_fault %0b want %0b", g.stack_fault, e.stack_fault));
         end
      endtask
   endclass

   logic clock;
   logic reset;
   int   src_idle;
   int   snk_stall;
   int   sent;
   bit   hold_kick;
   int   hold_count;

   core_scoreboard sb;

   ciu_chan_if #(.word_type(req_word_type)) req_if ();
   ciu_chan_if #(.word_type(rsp_word_type)) rsp_if ();
   ciu_chan_if #(.word_type(csr_word_type)) csr_if ();

   chip8_instruction_core_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.data = '0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.data = '0;
      hold_kick = 0;
      hold_count = 0;
      src_idle = 0;
      snk_stall = 0;
      sent = 0;
      sb = new();
   end

   always #2 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) sb.check(rsp_if.data);
         if (hold_kick && hold_count == 0) begin
            hold_count = 600;
            hold_kick <= 0;
         end
         if (hold_count > 0) begin
            hold_count--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= snk_stall);
         end
      end
   end

   task automatic send(logic [2:0] op, logic [11:0] addr, logic [7:0] wbyte);
      req_word_type w;
      w.op = op;
      w.address = addr;
      w.write_byte = wbyte;
      if (src_idle > 0 && $urandom_range(99) < src_idle) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data <= w;
      do @(posedge clock); while (!req_if.ready);
      sb.note(w);
      sent++;
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      while (sb.due.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_start(logic [11:0] a);
      drain();
      csr_if.valid <= 1'b1;
      csr_if.data <= a;
      do @(posedge clock); while (!csr_if.ready);
      sb.set_start(a);
      csr_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [15:0] rand_ins();
      logic [3:0] g;
      logic [3:0] x;
      logic [3:0] n;
      logic [7:0] nn;
      g = 4'($urandom_range(15));
      x = 4'($urandom_range(15));
      nn = $urandom_range(1) ? sb.v[x] : 8'($urandom_range(255));
      case (g)
         GRP_SYS: begin
            case ($urandom_range(9))
               0: return INS_CLS;
               1, 2, 3, 4: return INS_RET;
               default: return {4'h0, 12'($urandom_range(4095))};
            endcase
         end
         GRP_ALU: begin
            n = $urandom_range(3) != 0 ? 4'($urandom_range(7)) : 4'($urandom_range(15));
            if ($urandom_range(3) == 0) n = ALU_SHL;
            return {GRP_ALU, x, 4'($urandom_range(15)), n};
         end
         GRP_SEQI, GRP_SNEI: return {g, x, nn};
         default: return 16'({g, 12'($urandom_range(4095))});
      endcase
   endfunction

   task automatic noise();
      send(3'($urandom_range(7)), 12'($urandom_range(4095)), 8'($urandom_range(255)));
   endtask

   task automatic program_chunk();
      logic [11:0] base;
      logic [15:0] ins;
      int          k;
      base = sb.pc;
      k = $urandom_range(1, 6);
      for (int i = 0; i < k; i++) begin
         ins = rand_ins();
         send(OP_LOAD, base + 12'(2 * i), ins[15:8]);
         send(OP_LOAD, base + 12'(2 * i + 1), ins[7:0]);
      end
      for (int i = 0; i < k; i++) begin
         send(OP_STEP, 12'($urandom_range(4095)), 8'($urandom_range(255)));
         if ($urandom_range(3) == 0) noise();
      end
   endtask

   task automatic stack_burst();
      logic [11:0] a;
      int          calls;
      a = sb.pc;
      calls = DEF_STACK_DEPTH - sb.depth + 1;
      send(OP_LOAD, a, {GRP_CALL, a[11:8]});
      send(OP_LOAD, a + 12'd1, a[7:0]);
      repeat (calls) send(OP_STEP, '0, '0);
      a = sb.pc;
      send(OP_LOAD, a, INS_RET[15:8]);
      send(OP_LOAD, a + 12'd1, INS_RET[7:0]);
      repeat (DEF_STACK_DEPTH + 1) send(OP_STEP, '0, '0);
   endtask

   initial begin
      int          target;
      logic [11:0] starts [4];
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send(OP_LOAD, 12'h200, {GRP_LDI, 4'h0});
      send(OP_LOAD, 12'h201, 8'hFF);
      send(OP_STEP, '0, '0);
      send(OP_LOAD, 12'h202, {GRP_ALU, 4'h0});
      send(OP_LOAD, 12'h203, {4'h0, ALU_ADD});
      send(OP_STEP, '0, '0);
      send(OP_RD_REG, 12'd15, '0);
      send(OP_RD_REG, 12'd0, '0);
      send(OP_RD_REG, 12'd16, '0);
      send(OP_RD_REG, 12'hFFF, '0);
      send(OP_LOAD, 12'h204, INS_RET[15:8]);
      send(OP_LOAD, 12'h205, INS_RET[7:0]);
      send(OP_STEP, '0, '0);
      send(OP_LOAD, 12'hFFF, 8'hFF);
      send(OP_RD_BYTE, 12'hFFF, '0);
      send(OP_RD_PIXEL, 12'd2047, '0);
      send(OP_RD_PIXEL, 12'd2048, '0);
      send(3'd5, 12'hABC, 8'h55);
      send(3'd6, 12'h543, 8'hAA);
      send(3'd7, 12'hFFF, 8'hFF);
      write_start(12'hFFF);
      send(OP_LOAD, 12'hFFF, {GRP_LDIDX, 4'hF});
      send(OP_LOAD, 12'h000, 8'hFF);
      send(OP_STEP, '0, '0);
      send(OP_LOAD, 12'h001, {GRP_DRAW, 4'h0});
      send(OP_LOAD, 12'h002, 8'h0F);
      send(OP_STEP, '0, '0);
      send(OP_STEP, '0, '0);

      starts = '{12'h000, 12'hFFF, 12'($urandom_range(4095)), START_RESET};
      for (int ph = 0; ph < 4; ph++) begin
         write_start(starts[ph]);
         case (ph)
            0: begin src_idle = 0;  snk_stall = 0;  end
            1: begin src_idle = 60; snk_stall = 0;  end
            2: begin src_idle = 0;  snk_stall = 60; end
            default: begin src_idle = 17; snk_stall = 17; end
         endcase
         if (ph == 0) hold_kick <= 1;
         target = sent + 480;
         while (sent < target) begin
            case ($urandom_range(19))
               0: stack_burst();
               1, 2, 3: noise();
               default: program_chunk();
            endcase
         end
      end

      req_if.valid <= 1'b0;
      while (sb.due.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (sb.errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #100000000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
